[hw/rtl/evs_pkg.sv]
`default_nettype none

package evs_pkg;

   // configuration port shape
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_LIM    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_TICKS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_GAIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CAP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_MASK = 3'd5;

   // configuration bundle handed to the datapath
   typedef struct packed {
      logic        enable;
      logic [15:0] noise_lim;
      logic [30:0] fault_ticks;
      logic [31:0] rate_gain;
      logic [30:0] speed_cap;
      logic [3:0]  reverse_mask;
   } cfg_type;

   // one per-wheel state entry
   typedef struct packed {
      logic [31:0] prev;
      logic [31:0] total;
   } ent_type;

   // item after the read-modify-write stage
   typedef struct packed {
      logic [1:0]  wheel;
      logic [31:0] delta;
      logic [31:0] total;
      logic [31:0] mag;
      logic        sneg;
   } smp_type;

endpackage

`default_nettype wire

[hw/rtl/evs_csr.sv]
`default_nettype none

module evs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [evs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [evs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output evs_pkg::cfg_type               cfg
);
   import evs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode; writes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE:       cfg_in.enable       = csr_wdata[0];
            CSR_NOISE_LIM:    cfg_in.noise_lim    = csr_wdata[15:0];
            CSR_FAULT_TICKS:  cfg_in.fault_ticks  = csr_wdata[30:0];
            CSR_RATE_GAIN:    cfg_in.rate_gain    = csr_wdata[31:0];
            CSR_SPEED_CAP:    cfg_in.speed_cap    = csr_wdata[30:0];
            CSR_REVERSE_MASK: cfg_in.reverse_mask = csr_wdata[3:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/evs_state_mem.sv]
`default_nettype none

module evs_state_mem #(
   parameter int DEPTH = 4,
   parameter int AW    = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output evs_pkg::ent_type rd_data,
   output logic             rd_hit,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  evs_pkg::ent_type wr_data
);
   import evs_pkg::*;

   ent_type          mem_ff [DEPTH];
   ent_type          rd_data_ff;
   logic [DEPTH-1:0] valid_ff;
   logic             rd_hit_ff;

   // state array, registered read (read returns the value before a same-edge write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // per-entry written flags; rd_hit is low when an unwritten entry is read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_hit  = rd_hit_ff;

endmodule

`default_nettype wire

[hw/rtl/evs_vel_pipe.sv]
`default_nettype none

module evs_vel_pipe (
   input  logic                clock,
   input  logic                reset,
   input  evs_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  evs_pkg::smp_type    in_smp,
   output logic                in_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_wheel_out,
   output logic signed [31:0]  rsp_velocity,
   output logic signed [31:0]  rsp_total_count,
   output logic signed [31:0]  rsp_tick_delta,
   output logic                rsp_fault
);
   import evs_pkg::*;

   // stage 2: thresholds and multiply
   logic    s2_valid_ff, s2_valid_in;
   smp_type s2_smp_ff;
   logic    s2_free, s2_noise, s2_flt;
   logic [63:0] s2_prod;

   // stage 3: clamp and sign
   logic        s3_valid_ff, s3_valid_in;
   logic [1:0]  s3_wheel_ff;
   logic [31:0] s3_delta_ff, s3_total_ff;
   logic [63:0] s3_prod_ff;
   logic        s3_noise_ff, s3_flt_ff, s3_sneg_ff;
   logic        s3_free, s3_over;
   logic [31:0] s3_pm, s3_vel;
   logic        s3_fault;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_wheel_ff;
   logic [31:0] out_vel_ff, out_total_ff, out_delta_ff;
   logic        out_fault_ff;
   logic        o_free;

   // elastic flow: each stage moves when the next one has room
   assign o_free  = !out_valid_ff || !rsp_stall;
   assign s3_free = !s3_valid_ff || o_free;
   assign s2_free = !s2_valid_ff || s3_free;
   assign in_free = s2_free;

   assign s2_valid_in  = s2_free ? in_valid : s2_valid_ff;
   assign s3_valid_in  = s3_free ? s2_valid_ff : s3_valid_ff;
   assign out_valid_in = o_free ? s3_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // noise floor, fault limit, magnitude times scale
   always_comb begin
      s2_noise = s2_smp_ff.mag < {16'd0, cfg.noise_lim};
      s2_flt   = s2_smp_ff.mag > {1'b0, cfg.fault_ticks};
      s2_prod  = 64'(s2_smp_ff.mag) * 64'(cfg.rate_gain);
   end

   // zero on noise or fault, else clamp to max speed and sign
   always_comb begin
      s3_over = s3_prod_ff > {33'd0, cfg.speed_cap};
      s3_pm   = s3_over ? {1'b0, cfg.speed_cap} : s3_prod_ff[31:0];
      if (s3_noise_ff) begin
         s3_vel   = '0;
         s3_fault = 1'b0;
      end else if (s3_flt_ff) begin
         s3_vel   = '0;
         s3_fault = 1'b1;
      end else begin
         s3_vel   = s3_sneg_ff ? (32'd0 - s3_pm) : s3_pm;
         s3_fault = s3_over;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s2_free && in_valid) begin
         s2_smp_ff <= in_smp;
      end
      if (s3_free && s2_valid_ff) begin
         s3_wheel_ff <= s2_smp_ff.wheel;
         s3_delta_ff <= s2_smp_ff.delta;
         s3_total_ff <= s2_smp_ff.total;
         s3_prod_ff  <= s2_prod;
         s3_noise_ff <= s2_noise;
         s3_flt_ff   <= s2_flt;
         s3_sneg_ff  <= s2_smp_ff.sneg;
      end
      if (o_free && s3_valid_ff) begin
         out_wheel_ff <= s3_wheel_ff;
         out_vel_ff   <= s3_vel;
         out_total_ff <= s3_total_ff;
         out_delta_ff <= s3_delta_ff;
         out_fault_ff <= s3_fault;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_wheel_out   = out_wheel_ff;
   assign rsp_velocity    = out_vel_ff;
   assign rsp_total_count = out_total_ff;
   assign rsp_tick_delta  = out_delta_ff;
   assign rsp_fault       = out_fault_ff;

endmodule

`default_nettype wire

[hw/rtl/encoder_velocity_sampler.sv]
// Encoder velocity sampler.
// Request channel (req_valid / req_stall) carries one wheel's raw counter
// reading; an item is taken when req_valid is high and req_stall is low.
// The result channel (rsp_valid / rsp_stall) returns the wheel index, the
// Q16.16 velocity, the running count, the tick delta and a fault flag.
// Configuration is written through csr_wr_en / csr_index / csr_wdata,
// by the user only while the block is idle; the block does not enforce it.
// Steps: the state is read at the taking edge, then read-modify-write,
// multiply, and clamp into the output register follow as registered
// stages. Throughput: one item per cycle unless the receiver stalls; the
// per-wheel state RAM is read once and written once a cycle, with a
// bypass for back-to-back items on one wheel.
// Items taken while disabled, or for a wheel index at or above NUM_WHEELS,
// produce no result and leave the state alone.
// Reset clears the configuration, the pipeline and the per-entry written
// flags of the state RAM, so every wheel starts from zero; no sweep needed.
// When the receiver stalls, the result holds and the stages behind it keep
// filling; req_stall rises only once every stage is occupied.
`default_nettype none

module encoder_velocity_sampler #(
   parameter int NUM_WHEELS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_wheel,
   input  logic signed [31:0]             req_raw_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_wheel_out,
   output logic signed [31:0]             rsp_velocity,
   output logic signed [31:0]             rsp_total_count,
   output logic signed [31:0]             rsp_tick_delta,
   output logic                           rsp_fault,
   input  logic                           csr_wr_en,
   input  logic [evs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [evs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import evs_pkg::*;

   localparam int AW = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

   cfg_type cfg;

   logic          req_take, wheel_ok, s1_load, s1_adv, s1_free, pipe_free;
   logic          s1_valid_ff, s1_valid_in;
   logic [1:0]    s1_wheel_ff;
   logic [31:0]   s1_count_ff;
   logic [AW-1:0] rd_addr, s1_addr;
   ent_type       rd_data, cur_ent, wb_ent;
   logic          rd_hit;
   logic          lw_valid_ff;
   logic [AW-1:0] lw_addr_ff;
   ent_type       lw_ent_ff;
   logic [31:0]   delta, rdelta;
   logic          neg;
   smp_type       smp;

   evs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // intake: only enabled items for a wheel in range enter the pipeline
   assign req_take  = req_valid && !req_stall;
   assign wheel_ok  = ({30'd0, req_wheel} < 32'(NUM_WHEELS));
   assign s1_load   = req_take && cfg.enable && wheel_ok;
   assign s1_adv    = s1_valid_ff && pipe_free;
   assign s1_free   = !s1_valid_ff || pipe_free;
   assign req_stall = !s1_free;

   assign rd_addr = AW'({30'd0, req_wheel});
   assign s1_addr = AW'({30'd0, s1_wheel_ff});

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_wheel_ff <= req_wheel;
         s1_count_ff <= req_raw_count;
      end
      if (s1_adv) begin
         lw_addr_ff <= s1_addr;
         lw_ent_ff  <= wb_ent;
      end
   end

   // per-wheel state RAM
   evs_state_mem #(
      .DEPTH (NUM_WHEELS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (s1_load),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rd_hit  (rd_hit),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr),
      .wr_data (wb_ent)
   );

   // bypass the last write-back, which the RAM read may have missed
   always_comb begin
      if (lw_valid_ff && (lw_addr_ff == s1_addr)) begin
         cur_ent = lw_ent_ff;
      end else if (rd_hit) begin
         cur_ent = rd_data;
      end else begin
         cur_ent = '0;
      end
   end

   // delta, magnitude and updated state
   always_comb begin
      delta        = s1_count_ff - cur_ent.prev;
      rdelta       = cur_ent.prev - s1_count_ff;
      neg          = delta[31];
      wb_ent.prev  = s1_count_ff;
      wb_ent.total = cur_ent.total + delta;
      smp.wheel    = s1_wheel_ff;
      smp.delta    = delta;
      smp.total    = wb_ent.total;
      smp.mag      = neg ? rdelta : delta;
      smp.sneg     = neg ^ cfg.reverse_mask[s1_wheel_ff];
   end

   evs_vel_pipe u_pipe (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (s1_valid_ff),
      .in_smp          (smp),
      .in_free         (pipe_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_wheel_out   (rsp_wheel_out),
      .rsp_velocity    (rsp_velocity),
      .rsp_total_count (rsp_total_count),
      .rsp_tick_delta  (rsp_tick_delta),
      .rsp_fault       (rsp_fault)
   );

endmodule

`default_nettype wire

[hw/rtl/evs_checker.sv]
`default_nettype none

module evs_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_stall,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_wheel_out,
   input  logic signed [31:0] rsp_velocity,
   input  logic signed [31:0] rsp_total_count,
   input  logic signed [31:0] rsp_tick_delta,
   input  logic               rsp_fault
);

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_wheel_out)
         && $stable(rsp_velocity) && $stable(rsp_total_count)
         && $stable(rsp_tick_delta) && $stable(rsp_fault))
      else $error("stalled result changed");

   // an empty output stage means the whole pipeline has room
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("intake stalled with empty output");

   // a wheel that did not move has no speed and no fault
   a_zero_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tick_delta == 32'sd0) |-> (rsp_velocity == 32'sd0) && !rsp_fault)
      else $error("nonzero velocity for zero delta");

endmodule

bind encoder_velocity_sampler evs_checker u_evs_checker (.*);

`default_nettype wire
